>>> design/pairwise_histogram_accumulator_unit_macros.svh
// Assertion macros for the pairwise histogram accumulator checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef PAIRWISE_HISTOGRAM_ACCUMULATOR_UNIT_MACROS_SVH
`define PAIRWISE_HISTOGRAM_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define PHAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("phau assertion failed");

// Next-cycle implication, quiet during reset.
`define PHAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("phau assertion failed");

`endif

>>> design/phau_pkg.sv
// Shared types and constants of the pairwise histogram accumulator.
// No dependencies.
`default_nettype none

package phau_pkg;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 8;
  localparam int VAL_W     = 32;
  localparam int SMP_W     = 8;
  localparam int CNT_W     = 32;
  localparam int IN_DATA_W = 56;

  // tdata bit positions, lowest field first
  localparam int IDX_LSB = 0;
  localparam int VAL_LSB = IDX_LSB + IDX_W;
  localparam int SA_LSB  = VAL_LSB + VAL_W;
  localparam int SB_LSB  = SA_LSB + SMP_W;

  localparam logic [CMD_W-1:0] CMD_PRELOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCUMULATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ       = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_ACC_A,
    ST_ACC_B,
    ST_RD
  } state_e;

endpackage

`default_nettype wire

>>> design/phau_bin_ram.sv
// Bin count store: one write port, one registered read port.
// A read issued in the cycle of a write to the same entry returns the new data.
`default_nettype none

module phau_bin_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] byp_data_q;
  logic              byp_hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q    <= mem[raddr_i];
      byp_data_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else if (re_i) begin
      byp_hit_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_hit_q ? byp_data_q : rdata_q;

endmodule

`default_nettype wire

>>> design/phau_out_fifo.sv
// Two-entry result queue in front of the master port.
// Reports whether one more read may be started without overflowing.
`default_nettype none

module phau_out_fifo #(
  parameter int DATA_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  input  wire logic              pending_i,   // a push is due next edge
  output logic                   room_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic      [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] slot_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q, count_d;
  logic              pop;
  logic [2:0]        occ;

  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  assign occ     = 3'(count_q) + 3'(pending_i) - 3'(pop);
  assign room_o  = (occ < 3'd2);

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> design/pairwise_histogram_accumulator_unit.sv
// Pairwise histogram accumulator: preload runs ST_PRE, accumulate runs ST_ACC_A if the
// samples match and ST_ACC_A then ST_ACC_B if they differ (one read-modify-write per bin
// on the single RAM port pair). A read's count reaches the master port through the RAM read
// register and then the result queue; up to 1 item/cycle while the queue has room, the next
// transfer taken in the last cycle of the current item. Reset clears control and the result
// queue only; bin counts are undefined until preloaded, so there is no clearing pass.
`default_nettype none

module pairwise_histogram_accumulator_unit
  import phau_pkg::*;
#(
  parameter int BIN_COUNT   = 256,
  parameter int SAMPLE_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // bin_index[7:0], bin_value[39:8], sample_a[47:40], sample_b[55:48]
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
  // command[1:0]
  input  wire logic [CMD_W-1:0]     s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // bin_count[31:0]
  output logic      [CNT_W-1:0]     m_axis_tdata
);

  localparam int ADDR_W = $clog2(BIN_COUNT);
  localparam logic [16:0] BIN_LIMIT = 17'(BIN_COUNT);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] addr1_q, addr2_q;
  logic              ok1_q, ok2_q, eq_q;
  logic [VAL_W-1:0]  val_q;

  logic [SMP_W-1:0]  smask, a_m, b_m;
  logic [15:0]       idx_ext, a_ext, b_ext;
  logic              idx_ok, a_ok, b_ok;
  logic              can_take, room, xfer;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CNT_W-1:0]  wdata, rdata;
  logic              push;
  logic [CNT_W-1:0]  push_data;

  always_comb begin
    for (int i = 0; i < SMP_W; i++) begin
      smask[i] = (i < SAMPLE_BITS);
    end
  end

  assign a_m     = s_axis_tdata[SA_LSB +: SMP_W] & smask;
  assign b_m     = s_axis_tdata[SB_LSB +: SMP_W] & smask;
  assign idx_ext = {8'h00, s_axis_tdata[IDX_LSB +: IDX_W]};
  assign a_ext   = {8'h00, a_m};
  assign b_ext   = {8'h00, b_m};
  assign idx_ok  = ({1'b0, idx_ext} < BIN_LIMIT);
  assign a_ok    = ({1'b0, a_ext} < BIN_LIMIT);
  assign b_ok    = ({1'b0, b_ext} < BIN_LIMIT);

  // The last cycle of an item leaves the RAM read port free for the next one.
  always_comb begin
    case (state_q)
      ST_IDLE, ST_PRE, ST_ACC_B, ST_RD: can_take = 1'b1;
      ST_ACC_A:                         can_take = eq_q;
      default:                          can_take = 1'b0;
    endcase
  end

  assign s_axis_tready = can_take && room;
  assign xfer          = s_axis_tvalid && s_axis_tready;

  // Item capture; preload/read address in slot 1, accumulate uses both.
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      val_q <= s_axis_tdata[VAL_LSB +: VAL_W];
      eq_q  <= (a_m == b_m);
      if (s_axis_tuser == CMD_ACCUMULATE) begin
        addr1_q <= a_ext[ADDR_W-1:0];
        ok1_q   <= a_ok;
      end else begin
        addr1_q <= idx_ext[ADDR_W-1:0];
        ok1_q   <= idx_ok;
      end
      addr2_q <= b_ext[ADDR_W-1:0];
      ok2_q   <= b_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    we        = 1'b0;
    waddr     = addr1_q;
    wdata     = val_q;
    re        = 1'b0;
    raddr     = addr2_q;
    push      = 1'b0;
    push_data = ok1_q ? rdata : '0;

    case (state_q)
      ST_IDLE: begin
        state_d = ST_IDLE;
      end
      ST_PRE: begin
        we      = ok1_q;
        state_d = ST_IDLE;
      end
      ST_ACC_A: begin
        we    = ok1_q;
        wdata = rdata + (eq_q ? 32'd2 : 32'd1);
        if (eq_q) begin
          state_d = ST_IDLE;
        end else begin
          re      = 1'b1;
          state_d = ST_ACC_B;
        end
      end
      ST_ACC_B: begin
        we      = ok2_q;
        waddr   = addr2_q;
        wdata   = rdata + 32'd1;
        state_d = ST_IDLE;
      end
      ST_RD: begin
        push    = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (xfer) begin
      re    = 1'b1;
      raddr = (s_axis_tuser == CMD_ACCUMULATE) ? a_ext[ADDR_W-1:0]
                                               : idx_ext[ADDR_W-1:0];
      case (s_axis_tuser)
        CMD_PRELOAD:    state_d = ST_PRE;
        CMD_ACCUMULATE: state_d = ST_ACC_A;
        CMD_READ:       state_d = ST_RD;
        default:        state_d = ST_IDLE;
      endcase
    end
  end

  phau_bin_ram #(
    .DEPTH  (BIN_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (CNT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  phau_out_fifo #(
    .DATA_W (CNT_W)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pending_i   (state_q == ST_RD),
    .room_o      (room),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> design/phau_checker.sv
// Port-level checks for the pairwise histogram accumulator, bound to the top level.
// Uses phau_pkg and the assertion macros header.
`default_nettype none

`include "pairwise_histogram_accumulator_unit_macros.svh"

module phau_checker
  import phau_pkg::*;
#(
  parameter int SAMPLE_BITS = 8
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic [IN_DATA_W-1:0] s_axis_tdata,
  input wire logic [CMD_W-1:0]     s_axis_tuser,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [CNT_W-1:0]     m_axis_tdata
);

  logic [SMP_W-1:0] smask;
  logic             in_xfer, read_xfer, split_acc;

  always_comb begin
    for (int i = 0; i < SMP_W; i++) begin
      smask[i] = (i < SAMPLE_BITS);
    end
  end

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign read_xfer = in_xfer && (s_axis_tuser == CMD_READ);
  assign split_acc = in_xfer && (s_axis_tuser == CMD_ACCUMULATE) &&
                     ((s_axis_tdata[SA_LSB +: SMP_W] & smask) !=
                      (s_axis_tdata[SB_LSB +: SMP_W] & smask));

  `PHAU_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `PHAU_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // a result only appears in answer to an earlier read transfer
  `PHAU_ASSERT_IMP(a_out_from_read, $rose(m_axis_tvalid), $past(read_xfer, 2))
  // two distinct bins keep the RAM read port busy in ST_ACC_A, so the next item must wait
  `PHAU_ASSERT_NXT(a_split_busy, split_acc, !s_axis_tready)

endmodule

bind pairwise_histogram_accumulator_unit phau_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_phau_checker (.*);

`default_nettype wire
